/* rtl/sorted_list_insert_delete_assert.svh */
// Assertion macros for the sorted list block.
// Used by sorted_list_insert_delete; expects clk and arst_n in scope.
`ifndef SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SLD_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define SLD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sld_pkg.sv */
// Shared types and constants for the sorted list block.
// No dependencies.
package sld_pkg;

	localparam int unsigned SLD_CAPACITY = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_BAD_POS   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] value;
		logic [3:0]         position;
	} sld_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [4:0]         entry_count;
	} sld_rsp_t;

	// Broadcast to every cell in the chain.
	typedef struct packed {
		logic        ins;
		logic        del;
		logic [31:0] value;
	} sld_cmd_t;

	// Per-cell compare results.
	typedef struct packed {
		logic lt;
		logic eq;
	} sld_flags_t;

endpackage

/* rtl/sld_cell.sv */
// One storage cell of the sorted chain: holds a single entry and shifts
// toward or away from its neighbors on insert and delete. Uses sld_pkg.
module sld_cell import sld_pkg::*; (
	input  logic        clk,
	input  sld_cmd_t    cmd,
	input  logic        occupied,
	input  logic        left_lt,
	input  logic [31:0] left_entry,
	input  logic [31:0] right_entry,
	output logic [31:0] entry,
	output sld_flags_t  flags
);

	logic [31:0] entry_q;

	assign entry    = entry_q;
	assign flags.lt = occupied && ($signed(entry_q) < $signed(cmd.value));
	assign flags.eq = occupied && (entry_q == cmd.value);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			// slot is the first cell not below the value; cells past it move up
			if (!left_lt) begin
				entry_q <= left_entry;
			end else if (!flags.lt) begin
				entry_q <= cmd.value;
			end
		end else if (cmd.del && !flags.lt) begin
			// from the first match onward, pull from the right
			entry_q <= right_entry;
		end
	end

endmodule

/* rtl/sld_out_buf.sv */
// Result register with one skid entry, so an item can be taken while
// a finished result still waits. Uses sld_pkg.
module sld_out_buf import sld_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  sld_rsp_t push_data,
	output logic     full,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output sld_rsp_t rsp
);

	logic     out_valid_q;
	logic     skid_valid_q;
	sld_rsp_t out_q;
	sld_rsp_t skid_q;
	logic     take;

	assign take      = out_valid_q && !rsp_stall;
	assign full      = skid_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

/* rtl/sorted_list_insert_delete.sv */
// Sorted list of signed 32-bit values held in a chain of compare-and-shift cells.
// The result is registered in the output buffer, or held in its skid entry while the output stalls.
// Throughput: one transaction per cycle while req_stall is low; every cell compares and shifts at once.
// Reset clears the count and the handshake; cell contents stay undefined.
// Uses sld_pkg, sld_cell, sld_out_buf and sorted_list_insert_delete_assert.svh.
`include "sorted_list_insert_delete_assert.svh"

module sorted_list_insert_delete import sld_pkg::*; #(
	parameter int unsigned CAPACITY = SLD_CAPACITY
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  sld_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output sld_rsp_t rsp
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned READ_SLOTS = 16;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_next;
	logic [31:0]       entry [CAPACITY];
	sld_flags_t        flags [CAPACITY];
	logic [CAPACITY-1:0] eq_vec;
	logic [31:0]       read_view [READ_SLOTS];
	sld_cmd_t          cmd;
	sld_rsp_t          result;
	logic              accept;
	logic              full_list;
	logic              found;
	logic              pos_ok;
	logic              buf_full;

	assign accept    = req_valid && !req_stall;
	assign req_stall = buf_full;
	assign full_list = (count_q == CW'(CAPACITY));
	assign found     = |eq_vec;
	assign pos_ok    = (32'(req.position) < 32'(count_q))
		&& (32'(req.position) < 32'(CAPACITY));

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic        left_lt;
		logic [31:0] left_entry;
		logic [31:0] right_entry;

		if (i == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_entry = entry[i];
		end else begin : g_mid
			assign left_lt    = flags[i-1].lt;
			assign left_entry = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = entry[i];
		end else begin : g_inner
			assign right_entry = entry[i+1];
		end

		sld_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (IDX < count_q),
			.left_lt    (left_lt),
			.left_entry (left_entry),
			.right_entry(right_entry),
			.entry      (entry[i]),
			.flags      (flags[i])
		);

		assign eq_vec[i] = flags[i].eq;
	end

	for (genvar r = 0; r < READ_SLOTS; r++) begin : g_view
		if (r < CAPACITY) begin : g_real
			assign read_view[r] = entry[r];
		end else begin : g_pad
			assign read_view[r] = '0;
		end
	end

	always_comb begin
		cmd.ins           = 1'b0;
		cmd.del           = 1'b0;
		cmd.value         = req.value;
		count_next        = count_q;
		result.status     = ST_OK;
		result.read_value = '0;
		case (req.opcode)
			OP_INSERT: begin
				if (full_list) begin
					result.status = ST_FULL;
				end else begin
					cmd.ins    = accept;
					count_next = count_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (found) begin
					cmd.del    = accept;
					count_next = count_q - 1'b1;
				end else begin
					result.status = ST_NOT_FOUND;
				end
			end
			OP_READ: begin
				if (pos_ok) begin
					result.read_value = read_view[req.position];
				end else begin
					result.status = ST_BAD_POS;
				end
			end
			default: begin
				result.status = ST_OK;
			end
		endcase
		result.entry_count = 5'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	sld_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(result),
		.full     (buf_full),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	`SLD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
	`SLD_ASSERT_NEXT(a_insert_grows, cmd.ins, count_q == $past(count_q + 1'b1), "insert lost")
	`SLD_ASSERT_NEXT(a_delete_shrinks, cmd.del, count_q == $past(count_q - 1'b1), "delete lost")
	`SLD_ASSERT_NOW(a_skid_order, buf_full, rsp_valid, "skid entry held with empty output")

endmodule
